[hw/rtl/rsp_pkg.sv]
// ----------------------------------------------------------------------------
// Road segment projector package
// Shared types and fixed constants for the road segment projector.
// ----------------------------------------------------------------------------
`default_nettype none

package rsp_pkg;

    // Fixed point formats.
    localparam int FRAC_BITS  = 8;
    localparam int SCALE_FRAC = 32;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 80;
    localparam int MUL_B_W = 34;
    localparam int MUL_CNT_W = 6;

    // Shared divider widths.
    localparam int DIV_N_W = 32;
    localparam int DIV_D_W = 16;
    localparam int DIV_CNT_W = 5;

    // Pixel limits.
    localparam logic [14:0] PIX_MAX   = 15'd32767;
    localparam logic [16:0] Y_CAP     = 17'd98303;

    // Reciprocals for the constant divisions. Division by three is exact for
    // dividends below 2^17, division by fifty for dividends below 2^30.
    localparam logic [15:0] Y_RECIP    = 16'd43691;
    localparam int          Y_SHIFT    = 17;
    localparam logic [26:0] LANE_RECIP = 27'd85899346;
    localparam int          LANE_SHIFT = 32;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEPTH  = 2'd0;
    localparam logic [1:0] CFG_HALF_W = 2'd1;
    localparam logic [1:0] CFG_SCR_W  = 2'd2;
    localparam logic [1:0] CFG_SCR_H  = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_SCALE,
        ST_MUL_TX,
        ST_MUL_MX,
        ST_MUL_TY,
        ST_MUL_MY,
        ST_MUL_Y,
        ST_MUL_HW,
        ST_MUL_HW2,
        ST_MUL_LANE,
        ST_FINISH
    } rsp_state_t;

endpackage

`default_nettype wire

[hw/rtl/rsp_mul.sv]
// ----------------------------------------------------------------------------
// Shift-add multiplier
// Multiplies two unsigned operands one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_mul
    import rsp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [MUL_A_W-1:0] a,
    input  wire logic [MUL_B_W-1:0] b,
    output logic                    done,
    output logic [MUL_A_W-1:0]      product
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_B_W-1:0]   b_reg;
    logic [MUL_A_W-1:0]   acc_reg;

    // Control: count one cycle per multiplier bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: add the shifted multiplicand when the multiplier bit is set.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[MUL_A_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[MUL_B_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

[hw/rtl/rsp_div.sv]
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_div
    import rsp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DIV_N_W-1:0] dividend,
    input  wire logic [DIV_D_W-1:0] divisor,
    output logic                    done,
    output logic [DIV_N_W-1:0]      quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_N_W-1:0]   q_reg;
    logic [DIV_D_W:0]     rem_reg;
    logic [DIV_D_W-1:0]   dvs_reg;
    logic [DIV_D_W:0]     shifted;
    logic                 fits;

    // Trial subtraction of the divisor from the shifted remainder.
    assign shifted = {rem_reg[DIV_D_W-1:0], q_reg[DIV_N_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    // Control: one cycle per quotient bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            q_reg   <= {q_reg[DIV_N_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

[hw/rtl/road_segment_projector.sv]
// ----------------------------------------------------------------------------
// Road segment projector
// Projects road segments to the screen with curve and hill bending and a
// clip line, using one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Contents
//  in      | in_valid / in_stall   | one road segment
//  out     | out_valid / out_stall | projected segment and previous one
//  cfg     | cfg_valid / cfg_ready | register index and write data
//
// A segment with nonzero distance goes from acceptance to the result
// register through one divider pass for the scale, eight multiplier
// passes (the divisions by three and fifty run as reciprocal multiplies)
// and the finishing state. A zero-distance segment goes straight there.
// Reset clears the sums and loads the configuration defaults.
// in_stall is high while a segment is in work or its result cannot be
// handed over; a waiting result does not block the next transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module road_segment_projector
    import rsp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               first_of_frame,
    input  wire logic signed [18:0] camera_x,
    input  wire logic signed [18:0] camera_height,
    input  wire logic signed [18:0] segment_x,
    input  wire logic signed [18:0] segment_y,
    input  wire logic [15:0]        segment_distance,
    input  wire logic signed [11:0] segment_curve,
    input  wire logic signed [11:0] segment_hill,
    input  wire logic [3:0]         stripe_phase,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    visible,
    output logic signed [15:0]      centre_x,
    output logic signed [15:0]      centre_y,
    output logic [14:0]             half_width,
    output logic signed [15:0]      previous_x,
    output logic signed [15:0]      previous_y,
    output logic [14:0]             previous_width,
    output logic                    light_band,
    output logic                    lane_paint,
    output logic [14:0]             lane_width,
    output logic [14:0]             previous_lane_width,
    output logic signed [15:0]      clip_line
);

    // Configuration registers.
    logic [15:0] depth_reg, rhw_reg;
    logic [11:0] scr_w_reg, scr_h_reg;

    // Frame state.
    logic [31:0] curve_off_reg, hill_off_reg;
    logic [23:0] curve_slope_reg, hill_slope_reg;
    logic signed [15:0] clip_reg, last_x_reg, last_y_reg;
    logic [14:0] last_w_reg, last_lane_reg;

    // Latched segment.
    logic signed [18:0] cam_x_reg, cam_h_reg, seg_x_reg, seg_y_reg;
    logic [15:0] dist_reg;
    logic signed [11:0] curve_reg, hill_reg;
    logic [3:0] phase_reg;

    // Intermediate results.
    logic [31:0] scale_reg;
    logic [66:0] m_reg;
    logic        neg_reg;
    logic signed [15:0] cx_reg, cy_reg;
    logic [14:0] hw_reg, lw_reg;
    logic [26:0] wq_reg;
    logic [16:0] ycap_reg;
    logic [47:0] hw_prod_reg;

    // Sequencer.
    rsp_state_t state_reg, state_next;
    logic launch_reg, launch_next;

    // Shared units.
    logic               mul_start, mul_done, div_start, div_done;
    logic [MUL_A_W-1:0] mul_a, mul_p;
    logic [MUL_B_W-1:0] mul_b;
    logic [DIV_N_W-1:0] div_n, div_q;
    logic [DIV_D_W-1:0] div_d;

    // Output registers.
    logic out_valid_reg;
    logic vis_reg;
    logic signed [15:0] o_cx_reg, o_cy_reg, o_px_reg, o_py_reg, o_clip_reg;
    logic [14:0] o_hw_reg, o_pw_reg, o_lw_reg, o_plw_reg;
    logic o_light_reg, o_paint_reg;

    logic in_accept, load_ok;

    // Offsets from the camera in fixed point.
    logic signed [19:0] diff_x, diff_y;
    logic signed [33:0] dx, dy;
    logic [33:0] mag_x, mag_y;
    logic dneg_x, dneg_y;

    // Sum or difference around one in the scale format.
    logic [66:0] tz, one_v, m_calc;
    logic        neg_calc, dneg_sel;

    // Saturated pixel values.
    logic [38:0] sh_x;
    logic [39:0] sh_y;
    logic [14:0] sat_x;
    logic [16:0] ycap;
    logic [26:0] wq_calc;
    logic [14:0] y_q;
    logic [21:0] lane_q;
    logic        vis_calc;
    logic signed [15:0] clip_calc;

    function automatic logic signed [19:0] segment_x_ext(input logic signed [18:0] v);
        segment_x_ext = {v[18], v};
    endfunction

    assign in_accept = in_valid && !in_stall;
    assign load_ok   = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);

    assign diff_x = {segment_x_ext(seg_x_reg)} - {segment_x_ext(cam_x_reg)};
    assign diff_y = {segment_x_ext(seg_y_reg)} - {segment_x_ext(cam_h_reg)};
    assign dx = {{6{diff_x[19]}}, diff_x, 8'b0} + {{2{curve_off_reg[31]}}, curve_off_reg};
    assign dy = {{6{diff_y[19]}}, diff_y, 8'b0} - {{2{hill_off_reg[31]}}, hill_off_reg};
    assign mag_x  = dx[33] ? 34'(-dx) : 34'(dx);
    assign mag_y  = dy[33] ? 34'(-dy) : 34'(dy);
    assign dneg_x = dx[33];
    assign dneg_y = !dy[33] && (dy != 34'sd0);

    // Combine the product with one: one plus t, or the distance between them.
    always_comb
    begin
        tz       = {1'b0, mul_p[65:0]};
        one_v    = 67'd1 << (SCALE_FRAC + FRAC_BITS);
        dneg_sel = (state_reg == ST_MUL_TX) ? dneg_x : dneg_y;
        neg_calc = 1'b0;
        if (!dneg_sel)
        begin
            m_calc = one_v + tz;
        end
        else if (tz <= one_v)
        begin
            m_calc = one_v - tz;
        end
        else
        begin
            m_calc   = tz - one_v;
            neg_calc = 1'b1;
        end
    end

    // Shift, cap and saturate the scaled products; pick reciprocal quotients.
    always_comb
    begin
        sh_x    = mul_p[79:41];
        sh_y    = mul_p[79:40];
        sat_x   = (sh_x > 39'(PIX_MAX)) ? PIX_MAX : sh_x[14:0];
        ycap    = (sh_y > 40'(Y_CAP)) ? Y_CAP : sh_y[16:0];
        wq_calc = mul_p[59:33];
        y_q     = mul_p[Y_SHIFT+14:Y_SHIFT];
        lane_q  = mul_p[LANE_SHIFT+21:LANE_SHIFT];
    end

    // Operand selection for the shared units.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        div_n = '0;
        div_d = '0;
        case (state_reg)
            ST_DIV_SCALE:
            begin
                div_n = {depth_reg, 16'b0};
                div_d = dist_reg;
            end
            ST_MUL_TX:
            begin
                mul_a = MUL_A_W'(scale_reg);
                mul_b = mag_x;
            end
            ST_MUL_TY:
            begin
                mul_a = MUL_A_W'(scale_reg);
                mul_b = mag_y;
            end
            ST_MUL_MX, ST_MUL_MY:
            begin
                mul_a = MUL_A_W'(m_reg);
                mul_b = MUL_B_W'(state_reg == ST_MUL_MX ? scr_w_reg : scr_h_reg);
            end
            ST_MUL_Y:
            begin
                mul_a = MUL_A_W'(ycap_reg);
                mul_b = MUL_B_W'(Y_RECIP);
            end
            ST_MUL_HW:
            begin
                mul_a = MUL_A_W'(scale_reg);
                mul_b = MUL_B_W'(rhw_reg);
            end
            ST_MUL_HW2:
            begin
                mul_a = MUL_A_W'(hw_prod_reg);
                mul_b = MUL_B_W'(scr_w_reg);
            end
            ST_MUL_LANE:
            begin
                mul_a = MUL_A_W'(wq_reg);
                mul_b = MUL_B_W'(LANE_RECIP);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_start = launch_reg && (state_reg == ST_MUL_TX || state_reg == ST_MUL_MX
                        || state_reg == ST_MUL_TY || state_reg == ST_MUL_MY
                        || state_reg == ST_MUL_Y || state_reg == ST_MUL_HW
                        || state_reg == ST_MUL_HW2 || state_reg == ST_MUL_LANE);
    assign div_start = launch_reg && (state_reg == ST_DIV_SCALE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (segment_distance != 16'd0) ? ST_DIV_SCALE : ST_FINISH;
                end
            end
            ST_DIV_SCALE: if (div_done) state_next = ST_MUL_TX;
            ST_MUL_TX:    if (mul_done) state_next = ST_MUL_MX;
            ST_MUL_MX:    if (mul_done) state_next = ST_MUL_TY;
            ST_MUL_TY:    if (mul_done) state_next = ST_MUL_MY;
            ST_MUL_MY:    if (mul_done) state_next = ST_MUL_Y;
            ST_MUL_Y:     if (mul_done) state_next = ST_MUL_HW;
            ST_MUL_HW:    if (mul_done) state_next = ST_MUL_HW2;
            ST_MUL_HW2:   if (mul_done) state_next = ST_MUL_LANE;
            ST_MUL_LANE:  if (mul_done) state_next = ST_FINISH;
            ST_FINISH:    if (load_ok) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
        launch_next = (state_next != state_reg) && (state_next != ST_IDLE)
                      && (state_next != ST_FINISH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
        end
    end

    // Clip test on the finished segment.
    always_comb
    begin
        vis_calc  = (dist_reg != 16'd0) && (cy_reg < clip_reg);
        clip_calc = vis_calc ? cy_reg : clip_reg;
    end

    // Configuration and frame state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg       <= 16'd55050;
            rhw_reg         <= 16'd5000;
            scr_w_reg       <= 12'd550;
            scr_h_reg       <= 12'd1000;
            curve_off_reg   <= '0;
            hill_off_reg    <= '0;
            curve_slope_reg <= '0;
            hill_slope_reg  <= '0;
            clip_reg        <= 16'sd1000;
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            last_w_reg      <= '0;
            last_lane_reg   <= 15'd1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEPTH:  depth_reg <= cfg_data;
                    CFG_HALF_W: rhw_reg   <= cfg_data;
                    CFG_SCR_W:  scr_w_reg <= cfg_data[11:0];
                    CFG_SCR_H:  scr_h_reg <= cfg_data[11:0];
                    default:    depth_reg <= depth_reg;
                endcase
            end
            if (in_accept && first_of_frame)
            begin
                curve_off_reg   <= '0;
                hill_off_reg    <= '0;
                curve_slope_reg <= '0;
                hill_slope_reg  <= '0;
                clip_reg        <= $signed({4'b0, scr_h_reg});
            end
            if (state_reg == ST_FINISH && load_ok)
            begin
                clip_reg        <= clip_calc;
                last_x_reg      <= cx_reg;
                last_y_reg      <= cy_reg;
                last_w_reg      <= hw_reg;
                last_lane_reg   <= lw_reg;
                curve_off_reg   <= curve_off_reg + {{8{curve_slope_reg[23]}}, curve_slope_reg};
                curve_slope_reg <= curve_slope_reg + {{12{curve_reg[11]}}, curve_reg};
                hill_off_reg    <= hill_off_reg + {{8{hill_slope_reg[23]}}, hill_slope_reg};
                hill_slope_reg  <= hill_slope_reg + {{12{hill_reg[11]}}, hill_reg};
            end
        end
    end

    // Segment latch and intermediate results.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cam_x_reg <= camera_x;
            cam_h_reg <= camera_height;
            seg_x_reg <= segment_x;
            seg_y_reg <= segment_y;
            dist_reg  <= segment_distance;
            curve_reg <= segment_curve;
            hill_reg  <= segment_hill;
            phase_reg <= stripe_phase;
            cx_reg    <= '0;
            cy_reg    <= '0;
            hw_reg    <= '0;
            lw_reg    <= 15'd1;
        end
        if (div_done && state_reg == ST_DIV_SCALE)
        begin
            scale_reg <= div_q;
        end
        if (mul_done && (state_reg == ST_MUL_TX || state_reg == ST_MUL_TY))
        begin
            m_reg   <= m_calc;
            neg_reg <= neg_calc;
        end
        if (mul_done && state_reg == ST_MUL_MX)
        begin
            cx_reg <= neg_reg ? -$signed({1'b0, sat_x}) : $signed({1'b0, sat_x});
        end
        if (mul_done && state_reg == ST_MUL_MY)
        begin
            ycap_reg <= ycap;
        end
        if (mul_done && state_reg == ST_MUL_Y)
        begin
            cy_reg <= neg_reg ? -$signed({1'b0, y_q}) : $signed({1'b0, y_q});
        end
        if (mul_done && state_reg == ST_MUL_HW)
        begin
            hw_prod_reg <= mul_p[47:0];
        end
        if (mul_done && state_reg == ST_MUL_HW2)
        begin
            wq_reg <= wq_calc;
            hw_reg <= (wq_calc > 27'(PIX_MAX)) ? PIX_MAX : wq_calc[14:0];
        end
        if (mul_done && state_reg == ST_MUL_LANE)
        begin
            lw_reg <= (lane_q == 22'd0) ? 15'd1
                    : ((lane_q > 22'(PIX_MAX)) ? PIX_MAX : lane_q[14:0]);
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_FINISH && load_ok)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH && load_ok)
        begin
            vis_reg     <= vis_calc;
            o_cx_reg    <= cx_reg;
            o_cy_reg    <= cy_reg;
            o_hw_reg    <= hw_reg;
            o_px_reg    <= last_x_reg;
            o_py_reg    <= last_y_reg;
            o_pw_reg    <= last_w_reg;
            o_light_reg <= (phase_reg < 4'd7);
            o_paint_reg <= (phase_reg >= 4'd5);
            o_lw_reg    <= lw_reg;
            o_plw_reg   <= last_lane_reg;
            o_clip_reg  <= clip_calc;
        end
    end

    assign out_valid           = out_valid_reg;
    assign visible             = vis_reg;
    assign centre_x            = o_cx_reg;
    assign centre_y            = o_cy_reg;
    assign half_width          = o_hw_reg;
    assign previous_x          = o_px_reg;
    assign previous_y          = o_py_reg;
    assign previous_width      = o_pw_reg;
    assign light_band          = o_light_reg;
    assign lane_paint          = o_paint_reg;
    assign lane_width          = o_lw_reg;
    assign previous_lane_width = o_plw_reg;
    assign clip_line           = o_clip_reg;

    // Shared arithmetic units.
    rsp_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    rsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Road segment projector testbench
// Sends road segments through the projector under several register settings.
// A directed table covers the extremes, zero distance, stripe phases and the
// start of a frame. Random frames and noise follow. A local fixed-point
// predictor computes every projected segment, and each output transaction is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import rsp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One road segment as offered on the input channel.
    typedef struct {
        bit                 first_of_frame;
        logic signed [18:0] camera_x;
        logic signed [18:0] camera_height;
        logic signed [18:0] segment_x;
        logic signed [18:0] segment_y;
        logic [15:0]        segment_distance;
        logic signed [11:0] segment_curve;
        logic signed [11:0] segment_hill;
        logic [3:0]         stripe_phase;
    } segment_t;

    // One projected segment as seen on the output channel.
    typedef struct {
        logic        visible;
        logic [15:0] centre_x;
        logic [15:0] centre_y;
        logic [14:0] half_width;
        logic [15:0] previous_x;
        logic [15:0] previous_y;
        logic [14:0] previous_width;
        logic        light_band;
        logic        lane_paint;
        logic [14:0] lane_width;
        logic [14:0] previous_lane_width;
        logic [15:0] clip_line;
    } projection_t;

    // Directed row: a segment and, where it is obvious, its typed result.
    typedef struct {
        segment_t    seg;
        bit          typed;
        projection_t res;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic first_of_frame;
    logic signed [18:0] camera_x;
    logic signed [18:0] camera_height;
    logic signed [18:0] segment_x;
    logic signed [18:0] segment_y;
    logic [15:0] segment_distance;
    logic signed [11:0] segment_curve;
    logic signed [11:0] segment_hill;
    logic [3:0] stripe_phase;
    logic out_valid;
    logic out_stall;
    logic visible;
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;
    logic [14:0] half_width;
    logic signed [15:0] previous_x;
    logic signed [15:0] previous_y;
    logic [14:0] previous_width;
    logic light_band;
    logic lane_paint;
    logic [14:0] lane_width;
    logic [14:0] previous_lane_width;
    logic signed [15:0] clip_line;

    road_segment_projector uut (.*);

    // Shadow registers and road state of the predictor.
    logic [15:0] depth_reg, half_w_reg;
    logic [11:0] scr_w_reg, scr_h_reg;
    logic [31:0] curve_sum, hill_sum;
    logic [23:0] curve_rate, hill_rate;
    logic signed [31:0] clip_level, prev_x, prev_y, prev_w, prev_lane;

    projection_t pending_projections[$];
    int errors = 0;
    int segments_sent = 0;
    int projections_checked = 0;
    int visible_seen = 0;
    int config_phases = 0;
    bit sender_idling = 1;
    bit sink_idling = 1;
    bit long_hold_request = 0;

    // Clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog for a hung run.
    initial
    begin
        #40ms;
        $display("Regression FAIL");
        $finish;
    end

    // Projects one screen axis: mult * (1 + scale*d) / (div * 2^shift), saturated.
    function automatic logic signed [31:0] axis_pixel(logic [63:0] scale,
                                                     logic signed [63:0] d,
                                                     logic [11:0] mult,
                                                     int shift, int divisor);
        logic [63:0] mag;
        logic [127:0] prod, unit, sum, shifted;
        logic [63:0] quot;
        bit negative;
        negative = 0;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        prod = 128'(scale) * 128'(mag);
        unit = 128'd1 << (SCALE_FRAC + FRAC_BITS);
        if (d >= 0)
            sum = unit + prod;
        else if (prod <= unit)
            sum = unit - prod;
        else
        begin
            sum = prod - unit;
            negative = 1;
        end
        sum = sum * 128'(mult);
        shifted = sum >> shift;
        if (shifted > 128'hFFFF_FFFF)
            shifted = 128'hFFFF_FFFF;
        quot = 64'(shifted) / 64'(divisor);
        if (quot > 64'd32767)
            quot = 64'd32767;
        return negative ? -32'(quot) : 32'(quot);
    endfunction

    // Predicts the projection of one accepted segment and advances the road state.
    function automatic projection_t project_segment(segment_t s);
        projection_t r;
        logic [63:0] scale, wq;
        logic [127:0] wide;
        logic signed [63:0] lat, vert, cam_lat, cam_vert, seg_lat, seg_vert;
        logic signed [31:0] cx, cy, hw, lw;
        bit vis;
        cx = 0;
        cy = 0;
        hw = 0;
        lw = 1;
        vis = 0;
        if (s.first_of_frame)
        begin
            curve_sum = 0;
            curve_rate = 0;
            hill_sum = 0;
            hill_rate = 0;
            clip_level = 32'(scr_h_reg);
        end
        if (s.segment_distance != 0)
        begin
            scale = ({32'd0, depth_reg, 16'd0}) / 64'(s.segment_distance);
            cam_lat = s.camera_x;
            cam_vert = s.camera_height;
            seg_lat = s.segment_x;
            seg_vert = s.segment_y;
            lat = (seg_lat - cam_lat) * 256 + 64'(signed'(curve_sum));
            vert = (seg_vert - cam_vert) * 256 - 64'(signed'(hill_sum));
            cx = axis_pixel(scale, lat, scr_w_reg, SCALE_FRAC + FRAC_BITS + 1, 1);
            cy = axis_pixel(scale, -vert, scr_h_reg, SCALE_FRAC + FRAC_BITS, 3);
            wide = (128'(scale) * 128'(half_w_reg) * 128'(scr_w_reg)) >> (SCALE_FRAC + 1);
            wq = (wide > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : 64'(wide);
            hw = (wq > 64'd32767) ? 32767 : 32'(wq);
            wq = wq / 64'd50;
            lw = (wq < 1) ? 1 : ((wq > 64'd32767) ? 32767 : 32'(wq));
            if (cy < clip_level)
            begin
                vis = 1;
                clip_level = cy;
            end
        end
        r.visible = vis;
        r.centre_x = cx[15:0];
        r.centre_y = cy[15:0];
        r.half_width = hw[14:0];
        r.previous_x = prev_x[15:0];
        r.previous_y = prev_y[15:0];
        r.previous_width = prev_w[14:0];
        r.light_band = (s.stripe_phase < 7);
        r.lane_paint = (s.stripe_phase >= 5);
        r.lane_width = lw[14:0];
        r.previous_lane_width = prev_lane[14:0];
        r.clip_line = clip_level[15:0];
        prev_x = cx;
        prev_y = cy;
        prev_w = hw;
        prev_lane = lw;
        curve_sum = curve_sum + {{8{curve_rate[23]}}, curve_rate};
        curve_rate = curve_rate + {{12{s.segment_curve[11]}}, s.segment_curve};
        hill_sum = hill_sum + {{8{hill_rate[23]}}, hill_rate};
        hill_rate = hill_rate + {{12{s.segment_hill[11]}}, s.segment_hill};
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] expected, logic [15:0] actual);
        if (expected !== actual)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
            errors++;
        end
    endtask

    // Output side: random stall bursts, one long hold on request.
    int stall_left = 0;
    int hold_left = 0;
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall = 1'b1;
        end
        else if (long_hold_request)
        begin
            long_hold_request = 0;
            hold_left = 1500;
            out_stall = 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall = 1'b1;
        end
        else if (sink_idling && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            out_stall = 1'b1;
        end
        else
            out_stall = 1'b0;
    end

    // Output checker: each transaction against the oldest prediction.
    always @(posedge clk)
    begin
        projection_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_projections.size() == 0)
            begin
                $error("Unexpected output transaction");
                errors++;
            end
            else
            begin
                e = pending_projections.pop_front();
                check_field("visible", 16'(e.visible), 16'(visible));
                check_field("centre_x", e.centre_x, centre_x);
                check_field("centre_y", e.centre_y, centre_y);
                check_field("half_width", 16'(e.half_width), 16'(half_width));
                check_field("previous_x", e.previous_x, previous_x);
                check_field("previous_y", e.previous_y, previous_y);
                check_field("previous_width", 16'(e.previous_width), 16'(previous_width));
                check_field("light_band", 16'(e.light_band), 16'(light_band));
                check_field("lane_paint", 16'(e.lane_paint), 16'(lane_paint));
                check_field("lane_width", 16'(e.lane_width), 16'(lane_width));
                check_field("previous_lane_width", 16'(e.previous_lane_width),
                            16'(previous_lane_width));
                check_field("clip_line", e.clip_line, clip_line);
                projections_checked++;
                if (visible)
                    visible_seen++;
            end
        end
    end

    // Writes one configuration register and mirrors it in the predictor.
    task automatic write_register(logic [1:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DEPTH:  depth_reg = value;
            CFG_HALF_W: half_w_reg = value;
            CFG_SCR_W:  scr_w_reg = value[11:0];
            CFG_SCR_H:  scr_h_reg = value[11:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(logic [15:0] depth, logic [15:0] half_w,
                             logic [11:0] scr_w, logic [11:0] scr_h);
        write_register(CFG_DEPTH, depth);
        write_register(CFG_HALF_W, half_w);
        write_register(CFG_SCR_W, 16'(scr_w));
        write_register(CFG_SCR_H, 16'(scr_h));
        config_phases++;
    endtask

    task automatic wait_until_drained();
        while (pending_projections.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Offers one segment until it is accepted; a typed result replaces the prediction.
    task automatic send_segment(segment_t s, bit typed, projection_t typed_res);
        projection_t p;
        int gap;
        if (sender_idling && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid = 1'b0;
            end
        end
        @(negedge clk);
        in_valid = 1'b1;
        first_of_frame = s.first_of_frame;
        camera_x = s.camera_x;
        camera_height = s.camera_height;
        segment_x = s.segment_x;
        segment_y = s.segment_y;
        segment_distance = s.segment_distance;
        segment_curve = s.segment_curve;
        segment_hill = s.segment_hill;
        stripe_phase = s.stripe_phase;
        do
            @(posedge clk);
        while (in_stall);
        p = project_segment(s);
        if (typed)
            p = typed_res;
        pending_projections = {pending_projections, p};
        segments_sent++;
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic segment_t make_segment(bit fof, int cx, int ch, int sx, int sy,
                                              int seg_dist, int curve, int hill, int phase);
        segment_t s;
        s.first_of_frame = fof;
        s.camera_x = 19'(cx);
        s.camera_height = 19'(ch);
        s.segment_x = 19'(sx);
        s.segment_y = 19'(sy);
        s.segment_distance = 16'(seg_dist);
        s.segment_curve = 12'(curve);
        s.segment_hill = 12'(hill);
        s.stripe_phase = 4'(phase);
        return s;
    endfunction

    // Zero-distance result: nothing projected, previous values carried along.
    function automatic projection_t hidden_result(int px, int py, int pw, int pl,
                                                 int clip, int phase);
        projection_t r;
        r.visible = 0;
        r.centre_x = 0;
        r.centre_y = 0;
        r.half_width = 0;
        r.previous_x = 16'(px);
        r.previous_y = 16'(py);
        r.previous_width = 15'(pw);
        r.light_band = (phase < 7);
        r.lane_paint = (phase >= 5);
        r.lane_width = 1;
        r.previous_lane_width = 15'(pl);
        r.clip_line = 16'(clip);
        return r;
    endfunction

    function automatic segment_t random_noise();
        segment_t s;
        s.first_of_frame = $urandom_range(0, 1);
        s.camera_x = 19'($urandom);
        s.camera_height = 19'($urandom);
        s.segment_x = 19'($urandom);
        s.segment_y = 19'($urandom);
        s.segment_distance = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
        s.segment_curve = 12'($urandom);
        s.segment_hill = 12'($urandom);
        s.stripe_phase = 4'($urandom);
        return s;
    endfunction

    // A frame of segments front to back with random road shape, at most limit long.
    task automatic send_frame(int limit);
        segment_t s;
        projection_t unused;
        int count, seg_dist, phase, cam_x, cam_h, road_x, road_y;
        bit wild;
        count = $urandom_range(4, 40);
        if (count > limit)
            count = limit;
        seg_dist = $urandom_range(0, 300);
        phase = $urandom_range(0, 13);
        cam_x = $urandom_range(0, 4000) - 2000;
        cam_h = $urandom_range(500, 3000);
        road_x = $urandom_range(0, 2000) - 1000;
        road_y = $urandom_range(0, 2000) - 1000;
        wild = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < count; i++)
        begin
            s = make_segment(i == 0, cam_x, cam_h, road_x, road_y, seg_dist,
                             wild ? $urandom_range(0, 4095) - 2048
                                  : $urandom_range(0, 200) - 100,
                             wild ? $urandom_range(0, 4095) - 2048
                                  : $urandom_range(0, 200) - 100,
                             phase);
            send_segment(s, 0, unused);
            seg_dist = seg_dist + $urandom_range(1, 3000);
            if (seg_dist > 65535)
                seg_dist = 65535;
            phase = (phase + 1) % 14;
            road_x = road_x + $urandom_range(0, 400) - 200;
            road_y = road_y + $urandom_range(0, 400) - 200;
        end
    endtask

    // Random part of one register phase.
    task automatic random_phase(int target);
        projection_t unused;
        int start;
        start = segments_sent;
        while (segments_sent - start < target)
        begin
            if ($urandom_range(0, 4) == 0)
                send_segment(random_noise(), 0, unused);
            else
                send_frame(target - (segments_sent - start));
        end
    endtask

    directed_row_t directed[$];

    // Appends one row to the directed table.
    task automatic add_row(segment_t seg, bit typed, projection_t res);
        directed_row_t row;
        row.seg = seg;
        row.typed = typed;
        row.res = res;
        directed = {directed, row};
    endtask

    initial
    begin
        projection_t unused;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DEPTH;
        cfg_data = 16'd0;
        in_valid = 1'b0;
        first_of_frame = 1'b0;
        camera_x = 0;
        camera_height = 0;
        segment_x = 0;
        segment_y = 0;
        segment_distance = 0;
        segment_curve = 0;
        segment_hill = 0;
        stripe_phase = 0;
        out_stall = 1'b0;
        depth_reg = 16'd55050;
        half_w_reg = 16'd5000;
        scr_w_reg = 12'd550;
        scr_h_reg = 12'd1000;
        curve_sum = 0;
        curve_rate = 0;
        hill_sum = 0;
        hill_rate = 0;
        clip_level = 1000;
        prev_x = 0;
        prev_y = 0;
        prev_w = 0;
        prev_lane = 1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table under the reset register values.
        add_row(make_segment(1, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                hidden_result(0, 0, 0, 1, 1000, 0));
        add_row(make_segment(0, 0, 0, 0, 0, 0, 0, 0, 13), 1,
                hidden_result(0, 0, 0, 1, 1000, 13));
        add_row(make_segment(0, 5, 5, 5, 5, 0, 0, 0, 14), 1,
                hidden_result(0, 0, 0, 1, 1000, 14));
        add_row(make_segment(1, 0, 1500, 0, 0, 300, 0, 0, 4), 0, unused);
        add_row(make_segment(0, 0, 1500, 0, 0, 600, 100, -100, 5), 0, unused);
        add_row(make_segment(0, 0, 1500, 0, 0, 900, 2047, 2047, 6), 0, unused);
        add_row(make_segment(0, 0, 1500, 0, 0, 1200, -2048, -2048, 7), 0, unused);
        add_row(make_segment(0, 0, 1500, 0, 0, 1100, 0, 0, 8), 0, unused);
        add_row(make_segment(0, 0, 1500, 0, 0, 0, 0, 0, 15), 0, unused);
        add_row(make_segment(1, -262144, -262144, 262143, 262143, 1,
                             2047, -2048, 0), 0, unused);
        add_row(make_segment(1, 262143, 262143, -262144, -262144, 1,
                             -2048, 2047, 1), 0, unused);
        add_row(make_segment(1, 0, 0, 0, 0, 65535, 0, 0, 2), 0, unused);
        add_row(make_segment(0, 262143, -262144, -262144, 262143, 65535,
                             -1, 1, 3), 0, unused);
        add_row(make_segment(1, 0, 0, 0, 0, 1, 0, 0, 9), 0, unused);
        add_row(make_segment(0, 100, 2000, -100, 50, 2, 1, -1, 10), 0, unused);
        add_row(make_segment(0, 0, 2000, 0, 0, 50000, 0, 0, 11), 0, unused);
        add_row(make_segment(0, 0, 2000, 0, 0, 40000, 0, 0, 12), 0, unused);
        foreach (directed[i])
            send_segment(directed[i].seg, directed[i].typed, directed[i].res);
        release_input();
        wait_until_drained();

        // Register phases: reset values, extremes, minimum, random.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: configure(16'd55050, 16'd5000, 12'd550, 12'd1000);
                1: configure(16'd65535, 16'd65535, 12'd4095, 12'd4095);
                2: configure(16'd1, 16'd1, 12'd1, 12'd1);
                default: configure(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                                   12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
            endcase
            if (ph == 5)
            begin
                sender_idling = 0;
                sink_idling = 0;
            end
            if (ph == 1)
                long_hold_request = 1;
            random_phase(100);
            if (ph == 3)
            begin
                // Sender pauses until every pending projection has come back.
                release_input();
                wait_until_drained();
            end
            random_phase(105);
            release_input();
            wait_until_drained();
        end

        repeat (300) @(posedge clk);
        if (pending_projections.size() != 0)
        begin
            $error("%0d projections never arrived", pending_projections.size());
            errors++;
        end
        $display("Covered %0d segments in %0d register settings, %0d projections checked",
                 segments_sent, config_phases, projections_checked);
        $display("%0d of them visible, with one long output hold and idle bursts both sides",
                 visible_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/rsp_pkg.sv
hw/rtl/rsp_mul.sv
hw/rtl/rsp_div.sv
hw/rtl/road_segment_projector.sv
dv/testbench.sv
